@@ design/apg_pkg.sv @@
// Shared constants, types and float helpers for the padded acoustic property grid.
package apg_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [1:0] REG_PAD_WIDTH    = 2'd2;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN  = 32'hFFC0_0000;

  typedef struct packed {
    logic [23:0]        mant;
    logic signed [10:0] expo;
    logic               nan;
    logic               inf;
    logic               zero;
  } fp_unpk_t;

  function automatic logic [4:0] clz24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // Subnormal inputs are normalized here so every nonzero significand has its top bit set.
  function automatic fp_unpk_t fp_unpack(input logic [31:0] x);
    fp_unpk_t   u;
    logic [23:0] m;
    logic [4:0]  lz;
    m      = {|x[30:23], x[22:0]};
    lz     = clz24(m);
    u.mant = m << lz;
    u.expo = ((x[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, x[30:23]}))
             - $signed({6'b000000, lz});
    u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    u.zero = (x[30:0] == 31'd0);
    return u;
  endfunction

  // Round to nearest even; a carry out of the fraction moves into the exponent.
  function automatic logic [31:0] fp_round(input logic sgn, input logic [7:0] expf,
                                           input logic [23:0] mant, input logic g,
                                           input logic st);
    logic [30:0] base;
    logic        inc;
    base = {expf, mant[22:0]};
    inc  = g & (st | mant[0]);
    return {sgn, base + 31'(inc)};
  endfunction

endpackage

@@ design/apg_fmul.sv @@
// Four-stage IEEE single-precision multiplier with round to nearest even.
module apg_fmul (
  input  logic        clk,
  input  logic [3:0]  en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import apg_pkg::*;

  fp_unpk_t ua, ub;
  logic        sgn_c;
  logic        spec_c;
  logic [31:0] sval_c;

  logic [23:0]        a_ma, a_mb;
  logic signed [10:0] a_ea, a_eb;
  logic               a_sgn, a_spec;
  logic [31:0]        a_sval;

  logic [47:0]        prod_c;
  logic [47:0]        b_prod;
  logic signed [10:0] b_exp;
  logic               b_sgn, b_spec;
  logic [31:0]        b_sval;

  logic [47:0]        m_c, t_c, mask_c;
  logic signed [10:0] e2_c, neg_c;
  logic [5:0]         sh_c;

  logic [23:0] c_mant;
  logic        c_g, c_st, c_ovf, c_sgn, c_spec;
  logic [7:0]  c_expf;
  logic [31:0] c_sval;

  always_comb begin
    ua     = fp_unpack(a);
    ub     = fp_unpack(b);
    sgn_c  = a[31] ^ b[31];
    spec_c = 1'b1;
    if (ua.nan) begin
      sval_c = a | QUIET_BIT;
    end else if (ub.nan) begin
      sval_c = b | QUIET_BIT;
    end else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      sval_c = DEFAULT_NAN;
    end else if (ua.inf || ub.inf) begin
      sval_c = {sgn_c, 8'hFF, 23'd0};
    end else if (ua.zero || ub.zero) begin
      sval_c = {sgn_c, 31'd0};
    end else begin
      spec_c = 1'b0;
      sval_c = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_ma   <= ua.mant;
      a_mb   <= ub.mant;
      a_ea   <= ua.expo;
      a_eb   <= ub.expo;
      a_sgn  <= sgn_c;
      a_spec <= spec_c;
      a_sval <= sval_c;
    end
  end

  assign prod_c = a_ma * a_mb;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_prod <= prod_c;
      b_exp  <= a_ea + a_eb - 11'sd127;
      b_sgn  <= a_sgn;
      b_spec <= a_spec;
      b_sval <= a_sval;
    end
  end

  // Results below the normal range are shifted right, lost bits fold into sticky.
  always_comb begin
    m_c    = b_prod[47] ? b_prod : {b_prod[46:0], 1'b0};
    e2_c   = b_exp + $signed({10'd0, b_prod[47]});
    neg_c  = 11'sd1 - e2_c;
    sh_c   = (e2_c > 11'sd0) ? 6'd0 : ((neg_c > 11'sd48) ? 6'd48 : neg_c[5:0]);
    t_c    = m_c >> sh_c;
    mask_c = ~({48{1'b1}} << sh_c);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_mant <= t_c[47:24];
      c_g    <= t_c[23];
      c_st   <= (|t_c[22:0]) | (|(m_c & mask_c));
      c_expf <= (e2_c > 11'sd0) ? e2_c[7:0] : 8'd0;
      c_ovf  <= e2_c > 11'sd254;
      c_sgn  <= b_sgn;
      c_spec <= b_spec;
      c_sval <= b_sval;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (c_spec) begin
        y <= c_sval;
      end else if (c_ovf) begin
        y <= {c_sgn, 8'hFF, 23'd0};
      end else begin
        y <= fp_round(c_sgn, c_expf, c_mant, c_g, c_st);
      end
    end
  end

endmodule

@@ design/apg_frcp.sv @@
// Eight-stage IEEE single-precision reciprocal by pipelined restoring division.
module apg_frcp (
  input  logic        clk,
  input  logic [7:0]  en,
  input  logic [31:0] d,
  output logic [31:0] y
);
  import apg_pkg::*;

  localparam int DIV_STAGES = 6;
  localparam int STEPS      = 5;
  localparam int QW         = DIV_STAGES * STEPS;

  typedef struct packed {
    logic [23:0]        md;
    logic signed [10:0] ed;
    logic               sgn;
    logic               spec;
    logic [31:0]        sval;
  } rcp_carry_t;

  fp_unpk_t    ud;
  rcp_carry_t  car_c;
  rcp_carry_t  s1_car;

  rcp_carry_t  car_in [DIV_STAGES];
  logic [24:0] rem_in [DIV_STAGES];
  logic [QW-1:0] quo_in [DIV_STAGES];
  logic [24:0] rem_nx [DIV_STAGES];
  logic [QW-1:0] quo_nx [DIV_STAGES];

  rcp_carry_t  dv_car [DIV_STAGES];
  logic [24:0] dv_rem [DIV_STAGES];
  logic [QW-1:0] dv_quo [DIV_STAGES];

  logic [QW-1:0]      fq;
  logic [28:0]        n_c, t_c, mask_c;
  logic               stk_c;
  logic signed [10:0] re_c, neg_c;
  logic [4:0]         sh_c;
  rcp_carry_t         fc;

  always_comb begin
    ud          = fp_unpack(d);
    car_c.md    = ud.mant;
    car_c.ed    = ud.expo;
    car_c.sgn   = d[31];
    car_c.spec  = ud.nan | ud.inf | ud.zero;
    if (ud.nan) begin
      car_c.sval = d | QUIET_BIT;
    end else if (ud.inf) begin
      car_c.sval = {d[31], 31'd0};
    end else begin
      car_c.sval = {d[31], 8'hFF, 23'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_car <= car_c;
  end

  always_comb begin
    car_in[0] = s1_car;
    rem_in[0] = 25'h080_0000;
    quo_in[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      car_in[k] = dv_car[k-1];
      rem_in[k] = dv_rem[k-1];
      quo_in[k] = dv_quo[k-1];
    end
  end

  // Each stage produces STEPS quotient bits of 1.0 / significand.
  always_comb begin
    logic [24:0]   r;
    logic [QW-1:0] q;
    for (int k = 0; k < DIV_STAGES; k++) begin
      r = rem_in[k];
      q = quo_in[k];
      for (int j = 0; j < STEPS; j++) begin
        if (r >= {1'b0, car_in[k].md}) begin
          r = r - {1'b0, car_in[k].md};
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = {r[23:0], 1'b0};
      end
      rem_nx[k] = r;
      quo_nx[k] = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k+1]) begin
        dv_car[k] <= car_in[k];
        dv_rem[k] <= rem_nx[k];
        dv_quo[k] <= quo_nx[k];
      end
    end
  end

  // The top quotient bit is set only for a significand of exactly one.
  always_comb begin
    fq     = dv_quo[DIV_STAGES-1];
    fc     = dv_car[DIV_STAGES-1];
    n_c    = fq[QW-1] ? fq[QW-1:1] : fq[QW-2:0];
    stk_c  = (|dv_rem[DIV_STAGES-1]) | (fq[QW-1] & fq[0]);
    re_c   = (fq[QW-1] ? 11'sd254 : 11'sd253) - fc.ed;
    neg_c  = 11'sd1 - re_c;
    sh_c   = (re_c > 11'sd0) ? 5'd0 : ((neg_c > 11'sd29) ? 5'd29 : neg_c[4:0]);
    t_c    = n_c >> sh_c;
    mask_c = ~({29{1'b1}} << sh_c);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      if (fc.spec) begin
        y <= fc.sval;
      end else if (re_c > 11'sd254) begin
        y <= {fc.sgn, 8'hFF, 23'd0};
      end else begin
        y <= fp_round(fc.sgn, (re_c > 11'sd0) ? re_c[7:0] : 8'd0, t_c[28:5], t_c[4],
                      (|t_c[3:0]) | (|(n_c & mask_c)) | stk_c);
      end
    end
  end

endmodule

@@ design/padded_acoustic_property_grid.sv @@
// Top level: padded grid addressing, property pipeline and the two property memories.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | opcode, row, col, velocity_bits, density_bits
//  out     | output    | out_valid/out_stall | bulk_modulus_bits, buoyancy_bits, range_error
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// Nine register stages: eight carry the two chained multiplies and the reciprocal divider
// (five quotient bits per stage), the ninth holds the memory read or write and the result.
// One item is accepted per cycle while in_stall is low; results leave in item order.
// Every stage advances when it is empty or the stage after it advances, so bubbles are
// filled while a result waits on out_stall. Reset clears the valid bits and returns the
// size registers to their reset values; data registers and the memories are not cleared.
module padded_acoustic_property_grid #(
  parameter int MAX_ROWS = apg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = apg_pkg::DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [9:0]  row,
  input  logic [9:0]  col,
  input  logic [31:0] velocity_bits,
  input  logic [31:0] density_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] bulk_modulus_bits,
  output logic [31:0] buoyancy_bits,
  output logic        range_error,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import apg_pkg::*;

  localparam int NST   = 9;
  localparam int SZW   = 13;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic          op;
    logic          err;
    logic [AW-1:0] addr;
  } ctl_t;

  logic [8:0] grid_columns, grid_rows;
  logic [7:0] pad_width;

  logic [NST:1] valid, ready, en, vld_in;

  logic [SZW-1:0] rows_eff, cols_eff, prow, pcol, row_w, col_w, pad_w, r_sel, c_sel;
  logic           err_c;

  logic          s1_op, s1_err;
  logic [RW-1:0] s1_r;
  logic [CW-1:0] s1_c;
  ctl_t          ctl_st [2:8];

  logic [31:0] d_dly [1:4];
  logic [31:0] vsq, kmod, buoy;

  logic [31:0] mod_mem  [DEPTH];
  logic [31:0] buoy_mem [DEPTH];
  logic        mem_we;
  logic [31:0] mk_q, mb_q, k9, b9;
  logic        op9, err9;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= 9'd256;
      grid_rows    <= 9'd256;
      pad_width    <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_data;
        REG_GRID_ROWS:    grid_rows    <= cfg_data;
        REG_PAD_WIDTH:    pad_width    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A stage takes new contents when it is empty or its successor moves on.
  always_comb begin
    ready[NST] = !valid[NST] || !out_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  assign en       = ready;
  assign in_stall = !ready[1];
  assign vld_in   = {valid[NST-1:1], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (en & vld_in) | (~en & valid);
    end
  end

  // Sizes of zero act as one, sizes beyond the memory act as its bound.
  always_comb begin
    rows_eff = (grid_rows == 9'd0) ? SZW'(1) :
               ((SZW'(grid_rows) > SZW'(MAX_ROWS)) ? SZW'(MAX_ROWS) : SZW'(grid_rows));
    cols_eff = (grid_columns == 9'd0) ? SZW'(1) :
               ((SZW'(grid_columns) > SZW'(MAX_COLS)) ? SZW'(MAX_COLS) : SZW'(grid_columns));
    pad_w    = SZW'(pad_width);
    prow     = rows_eff + (pad_w << 1);
    pcol     = cols_eff + (pad_w << 1);
    row_w    = SZW'(row);
    col_w    = SZW'(col);
    if (opcode == OP_LOAD) begin
      err_c = (row_w >= rows_eff) || (col_w >= cols_eff);
      r_sel = row_w;
      c_sel = col_w;
    end else begin
      err_c = (row_w >= prow) || (col_w >= pcol);
      // Border points replicate the nearest interior edge, corners included.
      if (row_w < pad_w) r_sel = '0;
      else if (row_w - pad_w >= rows_eff) r_sel = rows_eff - SZW'(1);
      else r_sel = row_w - pad_w;
      if (col_w < pad_w) c_sel = '0;
      else if (col_w - pad_w >= cols_eff) c_sel = cols_eff - SZW'(1);
      else c_sel = col_w - pad_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op    <= opcode;
      s1_err   <= err_c;
      s1_r     <= RW'(r_sel);
      s1_c     <= CW'(c_sel);
      d_dly[1] <= density_bits;
    end
    if (en[2]) begin
      ctl_st[2].op   <= s1_op;
      ctl_st[2].err  <= s1_err;
      ctl_st[2].addr <= AW'(AW'(s1_r) * AW'(MAX_COLS)) + AW'(s1_c);
    end
    for (int k = 3; k <= 8; k++) begin
      if (en[k]) ctl_st[k] <= ctl_st[k-1];
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) d_dly[k] <= d_dly[k-1];
    end
  end

  apg_fmul u_vsq (
    .clk (clk),
    .en  (en[4:1]),
    .a   (velocity_bits),
    .b   (velocity_bits),
    .y   (vsq)
  );

  apg_fmul u_kmod (
    .clk (clk),
    .en  (en[8:5]),
    .a   (d_dly[4]),
    .b   (vsq),
    .y   (kmod)
  );

  apg_frcp u_buoy (
    .clk (clk),
    .en  (en[8:1]),
    .d   (density_bits),
    .y   (buoy)
  );

  // Loads and reads reach the memories in item order, so a read always sees earlier loads.
  assign mem_we = en[9] && valid[8] && (ctl_st[8].op == OP_LOAD) && !ctl_st[8].err;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mod_mem[ctl_st[8].addr]  <= kmod;
      buoy_mem[ctl_st[8].addr] <= buoy;
    end
    if (en[9]) begin
      mk_q <= mod_mem[ctl_st[8].addr];
      mb_q <= buoy_mem[ctl_st[8].addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      op9  <= ctl_st[8].op;
      err9 <= ctl_st[8].err;
      k9   <= kmod;
      b9   <= buoy;
    end
  end

  assign out_valid         = valid[NST];
  assign range_error       = err9;
  assign bulk_modulus_bits = err9 ? 32'd0 : ((op9 == OP_READ) ? mk_q : k9);
  assign buoyancy_bits     = err9 ? 32'd0 : ((op9 == OP_READ) ? mb_q : b9);

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&valid) && out_stall))
    else $error("input stalled while the pipeline has a free stage");

  a_empty_tail_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output stage");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (bulk_modulus_bits == 32'd0 && buoyancy_bits == 32'd0))
    else $error("range error result carries nonzero data");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the padded acoustic property grid.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apg_pkg::*;

  localparam int GRID_MAX = DEF_MAX_COLS;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [31:0] modulus;
    logic [31:0] buoyancy;
    logic        range_err;
  } grid_result_t;

  // Tracks the register settings and the two stores, predicts each result
  // and compares it when it leaves the block.
  class grid_scoreboard;
    int unsigned  columns_reg = 256, rows_reg = 256, pad_reg = 0;
    logic [31:0]  modulus_mem [int unsigned];
    logic [31:0]  buoyancy_mem [int unsigned];
    bit           loaded [int unsigned];
    int unsigned  loaded_pts [$];
    grid_result_t expected_props [$];
    int           errors = 0;

    function int unsigned eff_size(int unsigned v);
      if (v == 0) return 1;
      return (v > GRID_MAX) ? GRID_MAX : v;
    endfunction

    function int unsigned cols();  return eff_size(columns_reg); endfunction
    function int unsigned rows();  return eff_size(rows_reg);    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        REG_GRID_COLUMNS: columns_reg = val;
        REG_GRID_ROWS:    rows_reg = val;
        REG_PAD_WIDTH:    pad_reg = val[7:0];
        default: ;
      endcase
      // Reads are only aimed at points loaded under the current shape.
      loaded.delete();
      loaded_pts.delete();
    endfunction

    function logic [31:0] round_pack(bit sgn, longint unsigned sig, int expo);
      int msb, sh, be;
      longint unsigned q;
      bit g, st;
      if (sig == 0) return {sgn, 31'd0};
      msb = 63;
      while (!sig[msb]) msb--;
      sh = msb - 23;
      if (-149 - expo > sh) sh = -149 - expo;
      if (sh > 0) begin
        if (sh > 64) begin
          q = 0; g = 0; st = 1;
        end else begin
          q = (sh == 64) ? 64'd0 : sig >> sh;
          g = sig[sh-1];
          st = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
        end
        if (g && (st || q[0])) q++;
      end else begin
        q = sig << (-sh);
      end
      if (q[24]) begin
        q = q >> 1;
        sh++;
      end
      if (!q[23]) return {sgn, 8'd0, q[22:0]};
      be = expo + sh + 150;
      if (be >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, be[7:0], q[22:0]};
    endfunction

    function bit is_nan(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function bit is_inf(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction

    // Significand and exponent so that the value is sig * 2^(expo - 150).
    function longint unsigned sig_of(logic [31:0] x);
      return {40'd0, x[30:23] != 0, x[22:0]};
    endfunction

    function int exp_of(logic [31:0] x);
      return (x[30:23] == 0) ? 1 : int'(x[30:23]);
    endfunction

    function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      bit s;
      s = a[31] ^ b[31];
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if (is_inf(a) || is_inf(b)) begin
        if (a[30:0] == 0 || b[30:0] == 0) return DEFAULT_NAN;
        return {s, 8'hFF, 23'd0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      return round_pack(s, sig_of(a) * sig_of(b), exp_of(a) + exp_of(b) - 300);
    endfunction

    function logic [31:0] fp_recip(logic [31:0] d);
      longint unsigned num, q, r;
      if (is_nan(d)) return d | QUIET_BIT;
      if (is_inf(d)) return {d[31], 31'd0};
      if (d[30:0] == 0) return {d[31], 8'hFF, 23'd0};
      num = 64'd1 << 60;
      q = num / sig_of(d);
      r = num % sig_of(d);
      // The remainder folds into one extra sticky bit below the quotient.
      return round_pack(d[31], (q << 1) | (r != 0), 150 - exp_of(d) - 61);
    endfunction

    function int unsigned clamp_axis(int unsigned p, int unsigned size);
      if (p < pad_reg) return 0;
      p = p - pad_reg;
      return (p >= size) ? size - 1 : p;
    endfunction

    function void note_item(logic op, logic [9:0] r, logic [9:0] c,
                            logic [31:0] vel, logic [31:0] dens);
      grid_result_t res;
      int unsigned addr;
      res = '{32'd0, 32'd0, 1'b0};
      if (op == OP_LOAD) begin
        if (r >= rows() || c >= cols()) begin
          res.range_err = 1'b1;
        end else begin
          addr = r * GRID_MAX + c;
          res.modulus = fp_mul(dens, fp_mul(vel, vel));
          res.buoyancy = fp_recip(dens);
          modulus_mem[addr] = res.modulus;
          buoyancy_mem[addr] = res.buoyancy;
          if (!loaded.exists(addr)) loaded_pts.push_back(addr);
          loaded[addr] = 1;
        end
      end else begin
        if (r >= rows() + 2 * pad_reg || c >= cols() + 2 * pad_reg) begin
          res.range_err = 1'b1;
        end else begin
          addr = clamp_axis(r, rows()) * GRID_MAX + clamp_axis(c, cols());
          res.modulus = modulus_mem[addr];
          res.buoyancy = buoyancy_mem[addr];
        end
      end
      expected_props.push_back(res);
    endfunction

    function void check_result(logic [31:0] modulus, logic [31:0] buoyancy, logic range_err);
      grid_result_t exp_res;
      if (expected_props.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      exp_res = expected_props.pop_front();
      if (modulus !== exp_res.modulus) begin
        $error("bulk_modulus_bits: expected %h, got %h", exp_res.modulus, modulus);
        errors++;
      end
      if (buoyancy !== exp_res.buoyancy) begin
        $error("buoyancy_bits: expected %h, got %h", exp_res.buoyancy, buoyancy);
        errors++;
      end
      if (range_err !== exp_res.range_err) begin
        $error("range_error: expected %b, got %b", exp_res.range_err, range_err);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OP_LOAD;
  logic [9:0]  row = '0;
  logic [9:0]  col = '0;
  logic [31:0] velocity_bits = '0;
  logic [31:0] density_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] bulk_modulus_bits;
  logic [31:0] buoyancy_bits;
  logic        range_error;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_GRID_COLUMNS;
  logic [8:0]  cfg_data = '0;

  grid_scoreboard sb = new();
  bit send_busy_mode, recv_busy_mode;
  int idle_cycles = 0;

  padded_acoustic_property_grid i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap(bit busy);
    if (!busy) return 0;
    return $urandom_range(0, 19);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(bulk_modulus_bits, buoyancy_bits, range_error);
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("** padded_acoustic_property_grid: FAILED **");
      $finish;
    end
  end

  // Receiver: holds off for a drawn number of cycles, then takes one result.
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    forever begin
      n = draw_gap(recv_busy_mode);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(logic op, logic [9:0] r, logic [9:0] c,
                           logic [31:0] vel, logic [31:0] dens);
    int gap;
    gap = draw_gap(send_busy_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    row <= r;
    col <= c;
    velocity_bits <= vel;
    density_bits <= dens;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, r, c, vel, dens);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Waits until every result is back, then lets the pipeline settle before a reshape.
  task automatic reshape(logic [8:0] columns, logic [8:0] rows_val, logic [8:0] pad);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_props.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_GRID_COLUMNS, columns);
    write_reg(REG_GRID_ROWS, rows_val);
    write_reg(REG_PAD_WIDTH, pad);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 9))
      0: ;
      1: case ($urandom_range(0, 4))
           0: f = {f[31], 31'd0};
           1: f = {f[31], 8'hFF, 23'd0};
           2: f = {f[31], 8'hFF, f[22:0] | 23'd1};
           3: f = {f[31], 8'd0, f[22:0]};
           default: f = {f[31], 8'($urandom_range(0, 1) ? 254 : 1), f[22:0]};
         endcase
      2: f[30:23] = 8'($urandom_range(1, 254));
      default: f = {($urandom_range(0, 7) == 0), 8'($urandom_range(110, 145)), f[22:0]};
    endcase
    return f;
  endfunction

  function automatic int unsigned padded_coord(int unsigned p, int unsigned size);
    int unsigned pad;
    pad = sb.pad_reg;
    if (p == 0 && $urandom_range(0, 1)) return $urandom_range(0, pad);
    if (p == size - 1 && $urandom_range(0, 1)) return $urandom_range(p + pad, size + 2 * pad - 1);
    return p + pad;
  endfunction

  // Picks a read that lands on a loaded point, or one outside the padded grid.
  function automatic bit pick_read(output logic [9:0] r, output logic [9:0] c);
    int unsigned pr, pc, addr;
    pr = sb.rows() + 2 * sb.pad_reg;
    pc = sb.cols() + 2 * sb.pad_reg;
    if ($urandom_range(0, 7) == 0) begin
      r = 10'($urandom_range(0, 1023));
      c = 10'($urandom_range(0, 1023));
      case ($urandom_range(0, 2))
        0: r = 10'($urandom_range(pr, 1023));
        1: c = 10'($urandom_range(pc, 1023));
        default: begin
          r = 10'($urandom_range(pr, 1023));
          c = 10'($urandom_range(pc, 1023));
        end
      endcase
      return 1;
    end
    r = 10'($urandom_range(0, pr - 1));
    c = 10'($urandom_range(0, pc - 1));
    if (sb.loaded.exists(sb.clamp_axis(r, sb.rows()) * GRID_MAX + sb.clamp_axis(c, sb.cols())))
      return 1;
    if (sb.loaded_pts.size() == 0) return 0;
    addr = sb.loaded_pts[$urandom_range(0, sb.loaded_pts.size() - 1)];
    r = 10'(padded_coord(addr / GRID_MAX, sb.rows()));
    c = 10'(padded_coord(addr % GRID_MAX, sb.cols()));
    return 1;
  endfunction

  task automatic random_phase(int count);
    logic [9:0] r, c;
    repeat (count) begin
      if ($urandom_range(0, 99) < 55 && pick_read(r, c)) begin
        send_item(OP_READ, r, c, $urandom(), $urandom());
      end else begin
        r = 10'($urandom_range(0, sb.rows() - 1));
        c = 10'($urandom_range(0, sb.cols() - 1));
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1)) r = 10'($urandom_range(sb.rows(), 1023));
          else c = 10'($urandom_range(sb.cols(), 1023));
        end
        send_item(OP_LOAD, r, c, rand_float(), rand_float());
      end
    end
  endtask

  initial begin
    logic [31:0] dir_vel [12];
    logic [31:0] dir_dens [12];
    int k;
    dir_vel = '{32'h3F80_0000, 32'h0000_0000, 32'h7F80_0000, 32'h7FA0_0001,
                32'h4000_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000,
                32'h45BB_8000, 32'h8000_0000, 32'hFF80_0000, 32'h1F00_0000};
    dir_dens = '{32'h3F80_0000, 32'h4500_0000, 32'h0000_0000, 32'h3F80_0000,
                 32'h8000_0000, 32'h7F7F_FFFF, 32'h007F_FFFF, 32'hFFC1_2345,
                 32'h0000_0001, 32'h7F80_0000, 32'h0000_0000, 32'h2000_0000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: special values at every interior point of a 4 x 3 grid with a border of 2.
    reshape(9'd4, 9'd3, 9'd2);
    for (k = 0; k < 12; k++)
      send_item(OP_LOAD, 10'(k / 4), 10'(k % 4), dir_vel[k], dir_dens[k]);
    send_item(OP_LOAD, 10'd3, 10'd1, 32'h3F80_0000, 32'h3F80_0000);
    send_item(OP_LOAD, 10'd0, 10'd1023, 32'h3F80_0000, 32'h3F80_0000);
    send_item(OP_READ, 10'd0, 10'd0, '0, '0);
    send_item(OP_READ, 10'd0, 10'd7, '0, '0);
    send_item(OP_READ, 10'd6, 10'd0, '0, '0);
    send_item(OP_READ, 10'd6, 10'd7, '0, '0);
    send_item(OP_READ, 10'd3, 10'd3, '0, '0);
    send_item(OP_READ, 10'd7, 10'd0, '0, '0);
    send_item(OP_READ, 10'd0, 10'd8, '0, '0);
    send_item(OP_READ, 10'd1023, 10'd1023, '0, '0);

    for (k = 0; k < 8; k++) begin
      send_busy_mode = $urandom_range(0, 2) != 0;
      recv_busy_mode = $urandom_range(0, 2) != 0;
      case (k)
        0: reshape(9'd0, 9'd0, 9'd0);
        1: reshape(9'd256, 9'd256, 9'd255);
        2: reshape(9'd511, 9'd300, 9'd256);
        3: reshape(9'd1, 9'd256, 9'd7);
        4: reshape(9'd256, 9'd1, 9'd1);
        default: reshape(9'($urandom_range(1, 24)), 9'($urandom_range(1, 24)),
                         9'($urandom_range(0, 511)));
      endcase
      random_phase(85);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_props.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("** padded_acoustic_property_grid: PASSED **");
    else
      $display("** padded_acoustic_property_grid: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
design/apg_pkg.sv
design/apg_fmul.sv
design/apg_frcp.sv
design/padded_acoustic_property_grid.sv
verif/tb.sv
